>>> design/telemetry_line_parser_macros.svh
// ----------------------------------------------------------------------------
// Telemetry line parser assertion macros
// Shared assertion forms, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_LINE_PARSER_MACROS_SVH
`define TELEMETRY_LINE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tlp_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry line parser package
// Types, character codes, matcher positions and helper functions.
// ----------------------------------------------------------------------------
package tlp_pkg;

  localparam int ValueWidth = 16;
  localparam int OutValW    = 16;
  localparam int IndW       = 9;
  localparam int ChgW       = IndW + 2;
  localparam int PosW       = 5;
  localparam int SlotW      = 4;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  localparam logic [ValueWidth-1:0] ValueMax = {ValueWidth{1'b1}};
  localparam logic [IndW-1:0]       IndReset = 9'h040;

  localparam logic [7:0] CharNl  = 8'h0A;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharSp  = 8'h20;
  localparam logic [7:0] Char0   = 8'h30;
  localparam logic [7:0] Char1   = 8'h31;
  localparam logic [7:0] Char2   = 8'h32;
  localparam logic [7:0] Char9   = 8'h39;
  localparam logic [7:0] CharB   = 8'h42;
  localparam logic [7:0] CharF   = 8'h46;
  localparam logic [7:0] CharH   = 8'h48;
  localparam logic [7:0] CharL   = 8'h4C;
  localparam logic [7:0] CharP   = 8'h50;
  localparam logic [7:0] CharR   = 8'h52;
  localparam logic [7:0] CharS   = 8'h53;
  localparam logic [7:0] CharT   = 8'h54;
  localparam logic [7:0] CharW   = 8'h57;
  localparam logic [7:0] CharNone = 8'h00;

  localparam logic [PosW-1:0] PosIdle      = 5'd0;
  localparam logic [PosW-1:0] PosSpdFirst  = 5'd1;
  localparam logic [PosW-1:0] PosSpd       = 5'd2;
  localparam logic [PosW-1:0] PosBatFirst  = 5'd3;
  localparam logic [PosW-1:0] PosBat       = 5'd4;
  localparam logic [PosW-1:0] PosSeatbeltB = 5'd19;
  localparam logic [PosW-1:0] PosDone      = 5'd27;

  typedef struct packed {
    logic [7:0] data;
    logic       nl;
    logic       blank;
    logic       dig;
    logic [3:0] dval;
  } token_t;

  typedef struct packed {
    logic                matched;
    logic [OutValW-1:0]  speed;
    logic [OutValW-1:0]  battery;
    logic [IndW-1:0]     ind;
    logic [ChgW-1:0]     changed;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] idx;
  } bit_slot_t;

  function automatic logic [7:0] lit_char(logic [PosW-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      5'd0:    c = CharS;
      5'd6:    c = CharP;
      5'd8:    c = CharL;
      5'd10:   c = CharF;
      5'd12:   c = CharT;
      5'd13:   c = CharL;
      5'd15:   c = CharT;
      5'd16:   c = CharR;
      5'd18:   c = CharS;
      5'd19:   c = CharB;
      5'd21:   c = CharW;
      5'd22:   c = Char1;
      5'd24:   c = CharW;
      5'd25:   c = Char2;
      default: c = CharNone;
    endcase
    return c;
  endfunction

  function automatic bit_slot_t bit_slot(logic [PosW-1:0] pos);
    bit_slot_t s;
    s.valid = 1'b1;
    unique case (pos)
      5'd5:    s.idx = 4'd0;
      5'd7:    s.idx = 4'd1;
      5'd9:    s.idx = 4'd2;
      5'd11:   s.idx = 4'd3;
      5'd14:   s.idx = 4'd4;
      5'd17:   s.idx = 4'd5;
      5'd20:   s.idx = 4'd6;
      5'd23:   s.idx = 4'd7;
      5'd26:   s.idx = 4'd8;
      default: begin
        s.valid = 1'b0;
        s.idx   = 4'd0;
      end
    endcase
    return s;
  endfunction

  function automatic logic [ValueWidth-1:0] acc_digit(logic [ValueWidth-1:0] a,
                                                     logic [3:0] d);
    logic [ValueWidth+3:0] v;
    v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{ValueWidth{1'b0}}, d};
    if (v > {4'b0, ValueMax}) begin
      return ValueMax;
    end
    return v[ValueWidth-1:0];
  endfunction

endpackage

>>> design/tlp_front.sv
// ----------------------------------------------------------------------------
// Telemetry line parser front end
// Classifies each received byte and holds it in a two-word token queue.
// ----------------------------------------------------------------------------
module tlp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte_i,
  output logic            tok_valid_o,
  output tlp_pkg::token_t tok_o,
  input  logic            tok_ready_i
);

  tlp_pkg::token_t              tok_in;
  tlp_pkg::token_t              entry_q [tlp_pkg::QDepth];
  logic [tlp_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tlp_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tlp_pkg::QCntW-1:0]    count_q, count_d;
  logic                         do_push, do_pop;

  always_comb begin
    tok_in.data  = rx_byte_i;
    tok_in.nl    = (rx_byte_i == tlp_pkg::CharNl);
    tok_in.blank = (rx_byte_i == tlp_pkg::CharSp) ||
                   ((rx_byte_i >= tlp_pkg::CharTab) && (rx_byte_i <= tlp_pkg::CharCr));
    tok_in.dig   = (rx_byte_i >= tlp_pkg::Char0) && (rx_byte_i <= tlp_pkg::Char9);
    tok_in.dval  = tok_in.dig ? rx_byte_i[3:0] : 4'd0;
  end

  assign full        = (count_q == tlp_pkg::QCntW'(tlp_pkg::QDepth));
  assign tok_valid_o = (count_q != '0);
  assign tok_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = tok_valid_o && tok_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= tok_in;
    end
  end

  `include "telemetry_line_parser_macros.svh"

  `TLP_ASSERT_IMP(a_tokq_count, 1'b1, count_q <= tlp_pkg::QCntW'(tlp_pkg::QDepth), "token queue overflow")
  `TLP_ASSERT_NEXT(a_tokq_grow, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "token count slip")

endmodule

>>> design/tlp_back.sv
// ----------------------------------------------------------------------------
// Telemetry line parser back end
// Runs the record matcher on each token and builds the result of a line.
// ----------------------------------------------------------------------------
module tlp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  tlp_pkg::token_t  tok_i,
  output logic             tok_ready_o,
  output logic             res_valid_o,
  output tlp_pkg::result_t res_o,
  input  logic             res_ready_i
);

  logic [tlp_pkg::PosW-1:0]       pos_q, pos_d;
  logic [tlp_pkg::ValueWidth-1:0] spd_q, spd_d, bat_q, bat_d;
  logic [tlp_pkg::ValueWidth-1:0] held_spd_q, held_spd_d, held_bat_q, held_bat_d;
  logic [tlp_pkg::IndW-1:0]       bits_q, bits_d, held_ind_q, held_ind_d;
  logic                           has_match_q, has_match_d;
  logic                           nonblank_q, nonblank_d;
  logic                           fire, is_s, is01, mm, start;
  logic                           acc_zero;
  logic [tlp_pkg::ValueWidth-1:0] dval_ext;
  logic [7:0]                     lit;
  tlp_pkg::bit_slot_t             slot;
  logic [tlp_pkg::ValueWidth-1:0] new_spd, new_bat;
  logic [tlp_pkg::IndW-1:0]       new_ind;

  assign tok_ready_o = !(tok_i.nl && nonblank_q) || res_ready_i;
  assign fire        = tok_valid_i && tok_ready_o;
  assign res_valid_o = fire && tok_i.nl && nonblank_q;

  assign is_s     = (tok_i.data == tlp_pkg::CharS);
  assign is01     = (tok_i.data == tlp_pkg::Char0) || (tok_i.data == tlp_pkg::Char1);
  assign dval_ext = {{(tlp_pkg::ValueWidth-4){1'b0}}, tok_i.dval};
  assign lit      = tlp_pkg::lit_char(pos_q);
  assign slot     = tlp_pkg::bit_slot(pos_q);
  assign acc_zero = (spd_q == '0) && (bat_q == '0) && (bits_q == '0);

  assign new_spd = has_match_q ? spd_q : held_spd_q;
  assign new_bat = has_match_q ? bat_q : held_bat_q;
  assign new_ind = has_match_q ? bits_q : held_ind_q;

  always_comb begin
    res_o.matched = has_match_q;
    res_o.speed   = new_spd[tlp_pkg::OutValW-1:0];
    res_o.battery = new_bat[tlp_pkg::OutValW-1:0];
    res_o.ind     = new_ind;
    if (has_match_q) begin
      res_o.changed = {bits_q ^ held_ind_q, bat_q != held_bat_q, spd_q != held_spd_q};
    end else begin
      res_o.changed = '0;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    spd_d       = spd_q;
    bat_d       = bat_q;
    bits_d      = bits_q;
    has_match_d = has_match_q;
    nonblank_d  = nonblank_q;
    held_spd_d  = held_spd_q;
    held_bat_d  = held_bat_q;
    held_ind_d  = held_ind_q;
    mm          = 1'b0;
    start       = 1'b0;
    if (fire && tok_i.nl) begin
      if (nonblank_q && has_match_q) begin
        held_spd_d = spd_q;
        held_bat_d = bat_q;
        held_ind_d = bits_q;
      end
      pos_d       = tlp_pkg::PosIdle;
      spd_d       = '0;
      bat_d       = '0;
      bits_d      = '0;
      has_match_d = 1'b0;
      nonblank_d  = 1'b0;
    end else if (fire) begin
      if (!tok_i.blank) begin
        nonblank_d = 1'b1;
      end
      unique case (pos_q)
        tlp_pkg::PosIdle: begin
          start = is_s;
        end
        tlp_pkg::PosSpdFirst: begin
          if (tok_i.dig) begin
            spd_d = dval_ext;
            pos_d = tlp_pkg::PosSpd;
          end else begin
            mm = 1'b1;
          end
        end
        tlp_pkg::PosSpd: begin
          if (tok_i.dig) begin
            spd_d = tlp_pkg::acc_digit(spd_q, tok_i.dval);
          end else if (tok_i.data == tlp_pkg::CharB) begin
            pos_d = tlp_pkg::PosBatFirst;
          end else begin
            mm = 1'b1;
          end
        end
        tlp_pkg::PosBatFirst: begin
          if (tok_i.dig) begin
            bat_d = dval_ext;
            pos_d = tlp_pkg::PosBat;
          end else begin
            mm = 1'b1;
          end
        end
        tlp_pkg::PosBat: begin
          if (tok_i.dig) begin
            bat_d = tlp_pkg::acc_digit(bat_q, tok_i.dval);
          end else if (tok_i.data == tlp_pkg::CharH) begin
            pos_d = pos_q + 1'b1;
          end else begin
            mm = 1'b1;
          end
        end
        default: begin
          if (pos_q < tlp_pkg::PosDone) begin
            if (slot.valid) begin
              if (is01) begin
                if (tok_i.data == tlp_pkg::Char1) begin
                  bits_d[slot.idx] = 1'b1;
                end
                pos_d = pos_q + 1'b1;
                if (pos_q + 1'b1 == tlp_pkg::PosDone) begin
                  has_match_d = 1'b1;
                end
              end else begin
                mm = 1'b1;
              end
            end else if (tok_i.data == lit) begin
              pos_d = pos_q + 1'b1;
            end else if ((pos_q == tlp_pkg::PosSeatbeltB) && tok_i.dig) begin
              spd_d  = dval_ext;
              bat_d  = '0;
              bits_d = '0;
              pos_d  = tlp_pkg::PosSpd;
            end else begin
              mm = 1'b1;
            end
          end
        end
      endcase
      if (mm) begin
        if (is_s) begin
          start = 1'b1;
        end else begin
          pos_d = tlp_pkg::PosIdle;
        end
      end
      if (start) begin
        spd_d  = '0;
        bat_d  = '0;
        bits_d = '0;
        pos_d  = tlp_pkg::PosSpdFirst;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= tlp_pkg::PosIdle;
      spd_q       <= '0;
      bat_q       <= '0;
      bits_q      <= '0;
      has_match_q <= 1'b0;
      nonblank_q  <= 1'b0;
      held_spd_q  <= '0;
      held_bat_q  <= '0;
      held_ind_q  <= tlp_pkg::IndReset;
    end else begin
      pos_q       <= pos_d;
      spd_q       <= spd_d;
      bat_q       <= bat_d;
      bits_q      <= bits_d;
      has_match_q <= has_match_d;
      nonblank_q  <= nonblank_d;
      held_spd_q  <= held_spd_d;
      held_bat_q  <= held_bat_d;
      held_ind_q  <= held_ind_d;
    end
  end

  `include "telemetry_line_parser_macros.svh"

  `TLP_ASSERT_IMP(a_match_done, has_match_q, pos_q == tlp_pkg::PosDone, "match before record end")
  `TLP_ASSERT_IMP(a_start_clear, pos_q == tlp_pkg::PosSpdFirst, acc_zero, "record start not cleared")

endmodule

>>> design/tlp_outq.sv
// ----------------------------------------------------------------------------
// Telemetry line parser result queue
// Two-word queue that holds finished line results until they are popped.
// ----------------------------------------------------------------------------
module tlp_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tlp_pkg::result_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output tlp_pkg::result_t data_o
);

  tlp_pkg::result_t             entry_q [tlp_pkg::QDepth];
  logic [tlp_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tlp_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tlp_pkg::QCntW-1:0]    count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == tlp_pkg::QCntW'(tlp_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  `include "telemetry_line_parser_macros.svh"

  `TLP_ASSERT_IMP(a_no_lost_result, push_i, !full_o, "result offered while queue is full")

endmodule

>>> design/telemetry_line_parser.sv
// ----------------------------------------------------------------------------
// Telemetry line parser
// Splits a received byte stream into lines and reports the telemetry record
// found in each nonblank line.
// ----------------------------------------------------------------------------
// Bytes enter through a queue-style port: a word is taken when push is high
// and full is low. Results leave the same way: the oldest result is on the
// output ports while empty is low and is taken when pop is high.
// A front stage classifies each byte into a two-word token queue; a back
// stage runs the record matcher, one token per cycle unless a full result
// queue holds it at a newline, and writes the result of each nonblank line
// into a two-word result queue. Throughput is one byte per cycle, set by the
// matcher step, while no such hold applies. The result of a line is
// registered in the result queue when the back stage takes its newline.
// Reset empties both queues, clears the held speed and battery, and sets
// the held indicators to seatbelt only.
// When the receiver stalls, the result queue fills, the back stage holds at
// the next newline of a nonblank line, the token queue fills and full rises.
// ----------------------------------------------------------------------------
module telemetry_line_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   rx_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         line_matched_o,
  output logic [tlp_pkg::OutValW-1:0]  speed_value_o,
  output logic [tlp_pkg::OutValW-1:0]  battery_value_o,
  output logic [tlp_pkg::IndW-1:0]     indicator_bits_o,
  output logic [tlp_pkg::ChgW-1:0]     changed_mask_o
);

  logic             tok_valid, tok_ready;
  tlp_pkg::token_t  tok;
  logic             res_valid, res_full;
  tlp_pkg::result_t res, head;

  tlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_ready_i (tok_ready)
  );

  tlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (!res_full)
  );

  tlp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (head)
  );

  assign line_matched_o   = head.matched;
  assign speed_value_o    = head.speed;
  assign battery_value_o  = head.battery;
  assign indicator_bits_o = head.ind;
  assign changed_mask_o   = head.changed;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry line parser testbench
// Feeds byte streams through the queue-style input and checks every line
// report against a cycle-free model of the record matcher and the held
// values. Directed lines cover full records, saturation, restarts, blank
// lines and trailing bytes; a long receiver hold fills the block; random
// lines then run under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int HoldCycles  = 300;
  localparam int RandomBytes = 1140;
  localparam int DrainLimit  = 20000;
  localparam int TailStart   = tlp_pkg::PosBat + 1;

  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharVt  = 8'h0B;
  localparam logic [7:0] CharFf  = 8'h0C;
  localparam logic [7:0] CharTop = 8'hFF;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic [7:0]                   rx_byte_i;
  logic                         empty;
  logic                         pop;
  logic                         line_matched_o;
  logic [tlp_pkg::OutValW-1:0]  speed_value_o;
  logic [tlp_pkg::OutValW-1:0]  battery_value_o;
  logic [tlp_pkg::IndW-1:0]     indicator_bits_o;
  logic [tlp_pkg::ChgW-1:0]     changed_mask_o;

  telemetry_line_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .line_matched_o   (line_matched_o),
    .speed_value_o    (speed_value_o),
    .battery_value_o  (battery_value_o),
    .indicator_bits_o (indicator_bits_o),
    .changed_mask_o   (changed_mask_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Matcher and held-value state of the line model.
  logic [tlp_pkg::PosW-1:0]       seek_pos;
  logic [tlp_pkg::ValueWidth-1:0] speed_acc;
  logic [tlp_pkg::ValueWidth-1:0] battery_acc;
  logic [tlp_pkg::ValueWidth-1:0] speed_held;
  logic [tlp_pkg::ValueWidth-1:0] battery_held;
  logic [tlp_pkg::IndW-1:0]       flags_acc;
  logic [tlp_pkg::IndW-1:0]       flags_held;
  logic                           line_hit;
  logic                           line_busy;

  tlp_pkg::result_t line_reports_q[$];
  logic [7:0]       line_buf[$];
  string            record_tail;
  int               errors;
  int               sent_count;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_request;

  function automatic logic [tlp_pkg::ValueWidth-1:0] add_digit(
      logic [tlp_pkg::ValueWidth-1:0] a, logic [3:0] d);
    longint v;
    v = longint'(a) * 10 + longint'(d);
    return (v > longint'(tlp_pkg::ValueMax)) ? tlp_pkg::ValueMax
                                             : v[tlp_pkg::ValueWidth-1:0];
  endfunction

  function automatic logic [tlp_pkg::ValueWidth-1:0] widen_digit(logic [3:0] d);
    return {{(tlp_pkg::ValueWidth-4){1'b0}}, d};
  endfunction

  function automatic int flag_index(int idx);
    int n;
    n = 0;
    for (int i = 0; i < idx; i++) begin
      if (record_tail[i] == "?") n++;
    end
    return n;
  endfunction

  function automatic void open_record();
    speed_acc   = '0;
    battery_acc = '0;
    flags_acc   = '0;
    seek_pos    = tlp_pkg::PosSpdFirst;
  endfunction

  function automatic void miss_record(logic [7:0] b);
    if (b == tlp_pkg::CharS) open_record();
    else seek_pos = tlp_pkg::PosIdle;
  endfunction

  function automatic void step_matcher(logic [7:0] b);
    logic       is_dig;
    logic [3:0] dv;
    logic [7:0] c;
    is_dig = (b >= tlp_pkg::Char0 && b <= tlp_pkg::Char9);
    dv = is_dig ? 4'(b - tlp_pkg::Char0) : 4'd0;
    if (seek_pos >= tlp_pkg::PosDone) return;
    case (seek_pos)
      tlp_pkg::PosIdle: begin
        if (b == tlp_pkg::CharS) open_record();
      end
      tlp_pkg::PosSpdFirst: begin
        if (is_dig) begin
          speed_acc = widen_digit(dv);
          seek_pos  = tlp_pkg::PosSpd;
        end else miss_record(b);
      end
      tlp_pkg::PosSpd: begin
        if (is_dig) speed_acc = add_digit(speed_acc, dv);
        else if (b == tlp_pkg::CharB) seek_pos = tlp_pkg::PosBatFirst;
        else miss_record(b);
      end
      tlp_pkg::PosBatFirst: begin
        if (is_dig) begin
          battery_acc = widen_digit(dv);
          seek_pos    = tlp_pkg::PosBat;
        end else miss_record(b);
      end
      tlp_pkg::PosBat: begin
        if (is_dig) battery_acc = add_digit(battery_acc, dv);
        else if (b == tlp_pkg::CharH) seek_pos = tlp_pkg::PosW'(TailStart);
        else miss_record(b);
      end
      default: begin
        c = record_tail[seek_pos - TailStart];
        if (c == "?") begin
          if (b == tlp_pkg::Char0 || b == tlp_pkg::Char1) begin
            if (b == tlp_pkg::Char1) flags_acc[flag_index(seek_pos - TailStart)] = 1'b1;
            seek_pos = seek_pos + 1'b1;
            if (seek_pos == tlp_pkg::PosDone) line_hit = 1'b1;
          end else miss_record(b);
        end else if (b == c) begin
          seek_pos = seek_pos + 1'b1;
        end else if (seek_pos == tlp_pkg::PosSeatbeltB && is_dig) begin
          open_record();
          speed_acc = widen_digit(dv);
          seek_pos  = tlp_pkg::PosSpd;
        end else miss_record(b);
      end
    endcase
  endfunction

  function automatic void clear_line();
    seek_pos    = tlp_pkg::PosIdle;
    speed_acc   = '0;
    battery_acc = '0;
    flags_acc   = '0;
    line_hit    = 1'b0;
    line_busy   = 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    tlp_pkg::result_t r;
    if (b != tlp_pkg::CharNl) begin
      if (!(b == tlp_pkg::CharSp || (b >= tlp_pkg::CharTab && b <= tlp_pkg::CharCr))) begin
        line_busy = 1'b1;
      end
      step_matcher(b);
    end else begin
      if (line_busy) begin
        r.changed = '0;
        if (line_hit) begin
          r.changed[0]                 = (speed_acc != speed_held);
          r.changed[1]                 = (battery_acc != battery_held);
          r.changed[tlp_pkg::ChgW-1:2] = flags_acc ^ flags_held;
          speed_held   = speed_acc;
          battery_held = battery_acc;
          flags_held   = flags_acc;
        end
        r.matched = line_hit;
        r.speed   = speed_held;
        r.battery = battery_held;
        r.ind     = flags_held;
        line_reports_q.push_back(r);
      end
      clear_line();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_byte(b);
    sent_count++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(tlp_pkg::CharNl);
  endtask

  function automatic logic [7:0] noise_byte(bit allow_nl);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (!allow_nl && b == tlp_pkg::CharNl) b = tlp_pkg::CharS;
    return b;
  endfunction

  function automatic void put_noise(int n, bit allow_nl);
    for (int i = 0; i < n; i++) line_buf.push_back(noise_byte(allow_nl));
  endfunction

  function automatic void put_number();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) line_buf.push_back(tlp_pkg::Char0 + 8'($urandom_range(9)));
  endfunction

  function automatic void put_record();
    line_buf.push_back(tlp_pkg::CharS);
    put_number();
    line_buf.push_back(tlp_pkg::CharB);
    put_number();
    line_buf.push_back(tlp_pkg::CharH);
    for (int i = 0; i < record_tail.len(); i++) begin
      if (record_tail[i] == "?") line_buf.push_back(tlp_pkg::Char0 + 8'($urandom_range(1)));
      else line_buf.push_back(record_tail[i]);
    end
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(4))
      0:       return tlp_pkg::CharTab;
      1:       return CharVt;
      2:       return CharFf;
      3:       return tlp_pkg::CharCr;
      default: return tlp_pkg::CharSp;
    endcase
  endfunction

  task automatic run_random(input int n_bytes);
    int target;
    int kind;
    int cut;
    target = sent_count + n_bytes;
    while (sent_count < target) begin
      line_buf.delete();
      kind = $urandom_range(99);
      if (kind < 55) begin
        if ($urandom_range(3) == 0) put_noise($urandom_range(1, 4), 1'b0);
        put_record();
        if ($urandom_range(3) == 0) put_record();
        if ($urandom_range(3) == 0) put_noise($urandom_range(1, 4), 1'b0);
      end else if (kind < 75) begin
        put_record();
        cut = $urandom_range(line_buf.size() - 1);
        if ($urandom_range(1) == 0) begin
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end else begin
          case ($urandom_range(2))
            0:       line_buf[cut] = tlp_pkg::CharS;
            1:       line_buf[cut] = tlp_pkg::Char0 + 8'($urandom_range(9));
            default: line_buf[cut] = noise_byte(1'b0);
          endcase
        end
      end else if (kind < 85) begin
        for (int i = $urandom_range(6); i > 0; i--) line_buf.push_back(blank_byte());
      end else begin
        put_noise($urandom_range(1, 12), 1'b1);
      end
      foreach (line_buf[i]) send_byte(line_buf[i]);
      send_byte(tlp_pkg::CharNl);
    end
  endtask

  task automatic test_full_records();
    send_line("S120B87H1P0L1F0TL1TR0SB1W10W21");
    send_line("S120B87H1P0L1F0TL1TR0SB1W10W21");
    send_line("S0B0H0P1L0F1TL0TR1SB0W11W20");
  endtask

  task automatic test_saturation();
    send_line("S65535B65536H0P0L0F0TL0TR0SB0W10W20");
    send_line("S9999999B6553H1P1L1F1TL1TR1SB1W11W21");
  endtask

  task automatic test_restarts();
    send_line("S12BS3B4H1P0L0F0TL0TR0SB0W10W20");
    send_line("S1B2H0P0L0F0TL0TR0S5B6H1P1L0F0TL1TR1SB0W10W21");
    send_line("S1B2H0P0L0F0TL0TR0SB2W10W20");
  endtask

  task automatic test_blank_lines();
    send_byte(tlp_pkg::CharSp);
    send_byte(tlp_pkg::CharTab);
    send_byte(CharVt);
    send_byte(CharFf);
    send_byte(tlp_pkg::CharCr);
    send_byte(tlp_pkg::CharNl);
    send_byte(tlp_pkg::CharNl);
    send_byte(CharNul);
    send_byte(tlp_pkg::CharNl);
    send_byte(CharTop);
    send_byte(tlp_pkg::CharNl);
  endtask

  task automatic test_trailing_bytes();
    send_line("S5B6H1P1L1F1TL1TR1SB1W11W21S7B8H0P0L0F0TL0TR0SB0W10W20junk");
    send_line("noise S44B55H0P1L0F1TL0TR1SB1W10W21");
  endtask

  // The receiver holds off while short lines keep coming, so the block fills.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (40) send_line("x");
    push <= 1'b0;
    wait (!hold_request);
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RandomBytes / 4);
    send_idle_pct  = 56;
    recv_stall_pct = 0;
    run_random(RandomBytes / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    run_random(RandomBytes / 4);
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    run_random(RandomBytes / 4);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    while (line_reports_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    tlp_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (line_reports_q.size() == 0) begin
        $error("word popped with no line report expected");
        errors++;
      end else begin
        want = line_reports_q.pop_front();
        if (line_matched_o !== want.matched) begin
          $error("line_matched: expected %0d, got %0d", want.matched, line_matched_o);
          errors++;
        end
        if (speed_value_o !== want.speed) begin
          $error("speed_value: expected %0d, got %0d", want.speed, speed_value_o);
          errors++;
        end
        if (battery_value_o !== want.battery) begin
          $error("battery_value: expected %0d, got %0d", want.battery, battery_value_o);
          errors++;
        end
        if (indicator_bits_o !== want.ind) begin
          $error("indicator_bits: expected %h, got %h", want.ind, indicator_bits_o);
          errors++;
        end
        if (changed_mask_o !== want.changed) begin
          $error("changed_mask: expected %h, got %h", want.changed, changed_mask_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    errors         = 0;
    sent_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;
    record_tail    = "?P?L?F?TL?TR?SB?W1?W2?";
    push           = 1'b0;
    rx_byte_i      = '0;
    rst_ni         = 1'b0;
    speed_held     = '0;
    battery_held   = '0;
    flags_held     = tlp_pkg::IndReset;
    clear_line();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_records();
    test_saturation();
    test_restarts();
    test_blank_lines();
    test_trailing_bytes();
    test_backpressure();
    test_random_traffic();

    push <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    if (line_reports_q.size() != 0) begin
      $error("%0d line reports never arrived", line_reports_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
